FILE: hw/rtl/mbd_pkg.sv
// Shared types, constants and the button-to-bit map of the debouncer.
// No dependencies; imported by every module of the block.
package mbd_pkg;

    localparam int unsigned BUTTONS      = 9;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned DEBOUNCE_W   = 16;
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(12);
    localparam logic [BYTE_W-1:0]     BYTE_MASK      = 8'hFF;

    // register indexes (word address = byte address / 4)
    localparam logic [APB_ADDR_W-3:0] REG_DEBOUNCE = '0;

    // shift byte bit feeding each of buttons 0..7; button 8 is the start pin
    localparam logic [2:0] LANE_BIT [BYTE_W] = '{
        3'd1, 3'd4, 3'd3, 3'd2, 3'd7, 3'd6, 3'd5, 3'd0
    };

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [BYTE_W-1:0] shift_byte;
        logic              start_level;
    } t_poll_word;

    typedef struct packed {
        logic [BUTTONS-1:0] held_mask;
        logic [BUTTONS-1:0] press_mask;
        logic [BYTE_W-1:0]  raw_down;
    } t_result_word;

    typedef struct packed {
        logic stable;
        logic press;
    } t_lane_res;

endpackage

FILE: hw/rtl/mbd_lane.sv
// One button's debounce state: candidate, stable level and change time.
// Depends on mbd_pkg.
module mbd_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_sample,
    input  logic [mbd_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [mbd_pkg::DEBOUNCE_W-1:0]   i_debounce_ms,
    output mbd_pkg::t_lane_res               o_res
);
    import mbd_pkg::*;

    logic              r_cand, n_cand;
    logic              r_stable, n_stable;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TIME_W-1:0] elapsed;
    logic              changed;
    logic              settle;

    assign changed = i_sample != r_cand;
    // wraps modulo 2^32, so a backward timestamp reads as a long hold
    assign elapsed = i_now_ms - r_time;
    assign settle  = !changed && (i_sample != r_stable)
                     && (elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, i_debounce_ms});

    always_comb begin
        n_cand   = r_cand;
        n_stable = r_stable;
        n_time   = r_time;
        if (i_accept) begin
            if (changed) begin
                n_cand = i_sample;
                n_time = i_now_ms;
            end else if (settle) begin
                n_stable = i_sample;
            end
        end
    end

    assign o_res.stable = n_stable;
    assign o_res.press  = settle && i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand   <= 1'b0;
            r_stable <= 1'b0;
            r_time   <= '0;
        end else begin
            r_cand   <= n_cand;
            r_stable <= n_stable;
            r_time   <= n_time;
        end
    end

endmodule

FILE: hw/rtl/mbd_merge.sv
// Gathers the lane results into one result word held in an output register.
// Depends on mbd_pkg.
module mbd_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  mbd_pkg::t_lane_res           i_lane [mbd_pkg::BUTTONS],
    input  logic [mbd_pkg::BYTE_W-1:0]   i_raw_down,
    input  logic                         i_out_ready,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    output mbd_pkg::t_result_word        o_out
);
    import mbd_pkg::*;

    logic         r_valid;
    t_result_word r_word, n_word;

    always_comb begin
        n_word.raw_down = i_raw_down;
        for (int i = 0; i < BUTTONS; i++) begin
            n_word.held_mask[i]  = i_lane[i].stable;
            n_word.press_mask[i] = i_lane[i].press;
        end
    end

    // a waiting word leaving this cycle frees the register for the next one
    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out       = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word <= n_word;
        end
    end

endmodule

FILE: hw/rtl/multi_button_debouncer_unit.sv
// Top level of the nine-button timestamp debouncer: APB register, lanes, merge.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
// Usage:
//   Poll channel (i_in_valid / o_in_ready, payload i_poll): one word per poll
//   carrying the millisecond timestamp, the raw active-low shift byte and the
//   active-low start pin level.
//   Result channel (o_out_valid / i_out_ready, payload o_out): one word per
//   poll with the debounced held mask, the press pulses of that poll and the
//   inverted shift byte.
//   Latency: the result is valid the cycle after the poll is taken.
//   Throughput: one poll per cycle unless stalled. Nine lanes each do a 32-bit
//   subtract and compare in parallel; the single output register sets the rate.
//   Stall: while a result waits, a new poll is still taken if the receiver
//   takes the waiting word in the same cycle; otherwise o_in_ready drops.
//   Reset: synchronous, active low. All levels and change times clear to
//   zero, debounce_ms returns to 12 ms and the output register empties.
//   Register: debounce_ms at byte address 0 (16 bits, read back on prdata).
//   Write it only while no poll is in flight.
module multi_button_debouncer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // poll channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mbd_pkg::t_poll_word                i_poll,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mbd_pkg::t_result_word              o_out,
    // APB register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mbd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mbd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mbd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import mbd_pkg::*;

    logic [DEBOUNCE_W-1:0] r_debounce;
    logic                  cfg_write;
    logic                  sel_debounce;
    logic                  accept;
    logic [BYTE_W-1:0]     raw_down;
    logic                  start_down;
    logic [BUTTONS-1:0]    sample;
    t_lane_res             lane_res [BUTTONS];

    // ---- register port: zero wait states, word aligned
    assign pready       = 1'b1;
    assign sel_debounce = paddr[APB_ADDR_W-1:2] == REG_DEBOUNCE;
    assign cfg_write    = psel && penable && pwrite && pready && sel_debounce;
    assign prdata       = sel_debounce
                          ? {{(APB_DATA_W-DEBOUNCE_W){1'b0}}, r_debounce} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (cfg_write) begin
            r_debounce <= pwdata[DEBOUNCE_W-1:0];
        end
    end

    // ---- input decode: invert active-low levels, then route bits to buttons
    assign accept     = i_in_valid && o_in_ready;
    assign raw_down   = ~i_poll.shift_byte & BYTE_MASK;
    assign start_down = !i_poll.start_level;

    always_comb begin
        for (int i = 0; i < BYTE_W; i++) begin
            sample[i] = raw_down[LANE_BIT[i]];
        end
        sample[BUTTONS-1] = start_down;
    end

    // ---- one lane per button, all stepping on the same poll
    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        mbd_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_accept      (accept),
            .i_sample      (sample[g]),
            .i_now_ms      (i_poll.now_ms),
            .i_debounce_ms (r_debounce),
            .o_res         (lane_res[g])
        );
    end

    // ---- merge lane outcomes into the registered result word
    mbd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_lane      (lane_res),
        .i_raw_down  (raw_down),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
